@@ hw/rtl/bhc_pkg.sv @@
// Shared types and constant tables for the Hall-sensor commutation block.
// No dependencies.
package bhc_pkg;

    localparam int HALL_W  = 3;
    localparam int LEAD_W  = 3;
    localparam int STATE_W = 3;
    localparam int GATE_W  = 6;
    localparam int POS_OUT_W = 32;

    localparam logic [2:0] REG_HOME_ADDR = 3'd0;

    // high-side gate bits are active low
    localparam logic [GATE_W-1:0] GATE_INVERT = 6'h2A;
    localparam logic [STATE_W-1:0] STEPS_PER_REV = 3'd6;

    typedef struct packed {
        logic [STATE_W-1:0] rotor_state;
        logic [STATE_W-1:0] drive_index;
        logic [GATE_W-1:0]  gate_levels;
    } t_commute;

    function automatic logic [STATE_W-1:0] f_sensor_to_rotor(input logic [HALL_W-1:0] hall);
        logic [STATE_W-1:0] r;
        case (hall)
            3'd0:    r = 3'd7;
            3'd1:    r = 3'd5;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd1;
            3'd5:    r = 3'd0;
            3'd6:    r = 3'd2;
            3'd7:    r = 3'd7;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    function automatic logic [GATE_W-1:0] f_drive_byte(input logic [STATE_W-1:0] idx);
        logic [GATE_W-1:0] d;
        case (idx)
            3'd0:    d = 6'h12;
            3'd1:    d = 6'h18;
            3'd2:    d = 6'h09;
            3'd3:    d = 6'h21;
            3'd4:    d = 6'h24;
            3'd5:    d = 6'h06;
            default: d = 6'h00;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/bhc_commutate.sv @@
// Combinational commutation decode: sensor map, drive index, gate levels.
// Depends on bhc_pkg.
module bhc_commutate
    import bhc_pkg::*;
(
    input  logic [HALL_W-1:0]  i_hall_bits,
    input  logic [LEAD_W-1:0]  i_phase_lead,
    input  logic [STATE_W-1:0] i_home_state,
    output t_commute           o_commute
);

    logic [STATE_W-1:0] rotor;
    logic signed [5:0]  sum;
    logic signed [5:0]  rem;
    logic [STATE_W-1:0] idx;

    always_comb begin
        rotor = f_sensor_to_rotor(i_hall_bits);
        // range -5..16
        sum = $signed({3'b000, rotor}) - $signed({3'b000, i_home_state})
            + 6'(signed'(i_phase_lead)) + $signed({3'b000, STEPS_PER_REV});
        // truncating remainder: a negative sum is already above -6
        if (sum >= 6'sd12) begin
            rem = sum - 6'sd12;
        end else if (sum >= 6'sd6) begin
            rem = sum - 6'sd6;
        end else begin
            rem = sum;
        end
        idx = rem[STATE_W-1:0];
        o_commute.rotor_state = rotor;
        o_commute.drive_index = idx;
        o_commute.gate_levels = f_drive_byte(idx) ^ GATE_INVERT;
    end

endmodule

@@ hw/rtl/bhc_position.sv @@
// Rotor position tracker: previous state and wrapping signed counter.
// Depends on bhc_pkg.
module bhc_position
    import bhc_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [STATE_W-1:0]        i_rotor_state,
    output logic [POSITION_WIDTH-1:0] o_count_next
);

    logic [STATE_W-1:0]        r_prev;
    logic [POSITION_WIDTH-1:0] r_count;
    logic signed [3:0]         diff;
    logic signed [3:0]         step;

    always_comb begin
        diff = $signed({1'b0, i_rotor_state}) - $signed({1'b0, r_prev});
        // wrap across the 5 <-> 0 boundary of the sequence
        if (diff == 4'sd5) begin
            step = -4'sd1;
        end else if (diff == -4'sd5) begin
            step = 4'sd1;
        end else begin
            step = diff;
        end
        o_count_next = r_count + POSITION_WIDTH'(step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_prev  <= i_rotor_state;
            r_count <= o_count_next;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> r_prev == $past(i_rotor_state))
        else $error("previous rotor state not updated on advance");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_count) && $stable(r_prev))
        else $error("position state changed without an item");

    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_count == '0 && r_prev == '0)
        else $error("position state not cleared by reset");

endmodule

@@ hw/rtl/bldc_hall_commutation.sv @@
// Top level of the Hall-sensor six-step commutation block.
// Depends on bhc_pkg, bhc_commutate and bhc_position.
//
// Usage:
//   Sensor samples enter on the s_axis stream (hall bits and signed phase
//   lead); one result leaves on the m_axis stream for every sample: rotor
//   state, drive index, gate pin levels and the accumulated position.
//   home_state is written through the APB port at byte address 0, and the user
//   writes it only while the block is idle; the block does not enforce this.
//   Reads return it. Two register stages: input register and result register.
//   Throughput: one sample per clock while m_axis_tready is high; decode
//   and position update sit in one combinational pass between the two
//   registers.
//   Stall: when m_axis_tready is low the result holds, the input register
//   still takes one more sample, then s_axis_tready drops until the result
//   moves on. Position state advances only as a sample enters the result
//   register, so stalls never drop or repeat a count.
//   Reset (synchronous, active low): both stages empty, position counter,
//   previous rotor state and home_state cleared to zero.
module bldc_hall_commutation
    import bhc_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] hall_bits, [5:3] phase_lead, [7:6] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [2:0] rotor_state, [5:3] drive_index,
                                        // [11:6] gate_levels, [43:12] position, [47:44] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                      r_in_valid;
    logic [HALL_W-1:0]         r_hall;
    logic [LEAD_W-1:0]         r_lead;
    logic                      r_out_valid;
    t_commute                  r_commute;
    logic [POS_OUT_W-1:0]      r_position;
    logic [STATE_W-1:0]        r_home;

    logic                      advance;
    t_commute                  commute;
    logic [POSITION_WIDTH-1:0] count_next;
    logic [POS_OUT_W-1:0]      n_position;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    bhc_commutate u_commutate (
        .i_hall_bits  (r_hall),
        .i_phase_lead (r_lead),
        .i_home_state (r_home),
        .o_commute    (commute)
    );

    bhc_position #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_rotor_state (commute.rotor_state),
        .o_count_next  (count_next)
    );

    generate
        if (POSITION_WIDTH >= POS_OUT_W) begin : g_pos_trunc
            assign n_position = count_next[POS_OUT_W-1:0];
        end else begin : g_pos_sext
            assign n_position = {{(POS_OUT_W-POSITION_WIDTH){count_next[POSITION_WIDTH-1]}},
                                 count_next};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_hall <= s_axis_tdata[2:0];
            r_lead <= s_axis_tdata[5:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_commute  <= commute;
            r_position <= n_position;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_position, r_commute.gate_levels,
                            r_commute.drive_index, r_commute.rotor_state};

    // APB: single register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home <= '0;
        end else if (psel && penable && pwrite && paddr == REG_HOME_ADDR) begin
            r_home <= pwdata[STATE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HOME_ADDR) ? {29'd0, r_home} : 32'd0;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_commute.drive_index[2:1] == 2'b11
            |-> r_commute.gate_levels == GATE_INVERT)
        else $error("off index does not turn all switches off");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_position))
        else $error("stalled result lost or changed");

endmodule

@@ verif/bldc_hall_commutation_tb.sv @@
// Testbench for bldc_hall_commutation: directed table plus random sensor walks,
// results checked against an in-bench commutation predictor.
// Depends on bhc_pkg and the bldc_hall_commutation RTL.
`timescale 1ns / 1ps

module bldc_hall_commutation_tb;
    import bhc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PER_SET = 150;
    localparam int HOLD_CYCLES   = 64;
    localparam int NUM_ROWS      = 20;
    localparam int NUM_SETS      = 5;

    // sensor code to rotor state, drive index to drive byte
    localparam logic [2:0] HALL_TO_ROTOR [8] = '{3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7};
    localparam logic [5:0] DRIVE_PATTERN [8] =
        '{6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00};
    // sensor code that yields rotor state 0..5 on a clean rotation
    localparam logic [2:0] ROTOR_TO_HALL [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    typedef struct packed {
        logic [2:0]  rotor_state;
        logic [2:0]  drive_index;
        logic [5:0]  gate_levels;
        logic [31:0] position;
    } t_commute_result;

    typedef struct packed {
        logic [2:0] home;
        logic [2:0] hall;
        logic [2:0] lead;      // two's complement
        logic       typed;     // rotor/index/gate given in the row
        logic [2:0] rotor;
        logic [2:0] index;
        logic [5:0] gate;
    } t_sample_row;

    localparam t_sample_row SAMPLE_ROWS [NUM_ROWS] = '{
        // home hall lead typed rotor index gate
        '{3'd0, 3'd5, 3'b000, 1'b1, 3'd0, 3'd0, 6'h38},   // first sample after reset
        '{3'd0, 3'd4, 3'b000, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd0, 3'd6, 3'b001, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd0, 3'd2, 3'b010, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd0, 3'd3, 3'b011, 1'b0, 3'd0, 3'd0, 6'h00},   // largest lead
        '{3'd0, 3'd1, 3'b100, 1'b0, 3'd0, 3'd0, 6'h00},   // lead of minus four
        '{3'd0, 3'd5, 3'b111, 1'b0, 3'd0, 3'd0, 6'h00},   // 5 -> 0 counts +1
        '{3'd0, 3'd1, 3'b110, 1'b0, 3'd0, 3'd0, 6'h00},   // 0 -> 5 counts -1
        '{3'd0, 3'd0, 3'b101, 1'b0, 3'd0, 3'd0, 6'h00},   // invalid code 000
        '{3'd0, 3'd7, 3'b000, 1'b0, 3'd0, 3'd0, 6'h00},   // invalid code 111
        '{3'd0, 3'd6, 3'b010, 1'b0, 3'd0, 3'd0, 6'h00},   // 7 -> 2 counts +1
        '{3'd0, 3'd0, 3'b000, 1'b0, 3'd0, 3'd0, 6'h00},   // 2 -> 7 counts -1
        '{3'd7, 3'd5, 3'b000, 1'b1, 3'd0, 3'd7, 6'h2A},   // sum -1: all switches off
        '{3'd7, 3'd5, 3'b111, 1'b1, 3'd0, 3'd6, 6'h2A},   // sum -2: all switches off
        '{3'd7, 3'd5, 3'b100, 1'b1, 3'd0, 3'd3, 6'h0B},   // most negative sum
        '{3'd7, 3'd3, 3'b011, 1'b1, 3'd4, 3'd0, 6'h38},
        '{3'd7, 3'd0, 3'b011, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd3, 3'd4, 3'b100, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd3, 3'd2, 3'b010, 1'b0, 3'd0, 3'd0, 6'h00},
        '{3'd3, 3'd7, 3'b110, 1'b0, 3'd0, 3'd0, 6'h00}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [2:0] hall_bits, [5:3] phase_lead, [7:6] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // [2:0] rotor_state, [5:3] drive_index,
                                   // [11:6] gate_levels, [43:12] position, [47:44] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bldc_hall_commutation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [2:0]  home_setting;
    logic [2:0]  last_rotor;
    logic [31:0] position_count;

    t_commute_result pending_results[$];
    int  fail_count;
    int  samples_sent;
    int  results_checked;
    int  cycle_count;
    bit  no_idle;
    bit  hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_commute_result predict_commutation(input logic [2:0] hall,
                                                            input logic [2:0] lead);
        t_commute_result r;
        int lead_val;
        int sum;
        int step;
        logic [31:0] rem_bits;
        r.rotor_state = HALL_TO_ROTOR[hall];
        lead_val = lead[2] ? int'(lead) - 8 : int'(lead);
        sum = int'(r.rotor_state) - int'(home_setting) + lead_val + 6;
        rem_bits = sum % 6;                         // truncates toward zero
        r.drive_index = rem_bits[2:0];
        r.gate_levels = DRIVE_PATTERN[r.drive_index] ^ GATE_INVERT;
        step = int'(r.rotor_state) - int'(last_rotor);
        if (step == 5)
            step = -1;
        else if (step == -5)
            step = 1;
        position_count = position_count + step;
        last_rotor = r.rotor_state;
        r.position = position_count;
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] expected,
                                            input logic [31:0] actual);
        fail_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, what, expected, actual);
    endfunction

    // one sample transfer; valid stays high afterwards so back-to-back samples need no gap
    task automatic send_sample(input logic [2:0] hall, input logic [2:0] lead,
                               input t_sample_row row);
        int gap;
        t_commute_result r;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, lead, hall};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_commutation(hall, lead);
        if (row.typed) begin
            r.rotor_state = row.rotor;
            r.drive_index = row.index;
            r.gate_levels = row.gate;
        end
        pending_results = {pending_results, r};
        samples_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_home(input logic [2:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HOME_ADDR;
        pwdata  <= {29'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        home_setting = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {29'd0, value})
            report_mismatch("home_state readback", {29'd0, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        t_commute_result want;
        t_commute_result got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = {m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[11:6],
                   m_axis_tdata[43:12]};
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with nothing expected, expected none actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.rotor_state !== want.rotor_state)
                    report_mismatch("rotor_state", 32'(want.rotor_state),
                                    32'(got.rotor_state));
                if (got.drive_index !== want.drive_index)
                    report_mismatch("drive_index", 32'(want.drive_index),
                                    32'(got.drive_index));
                if (got.gate_levels !== want.gate_levels)
                    report_mismatch("gate_levels", 32'(want.gate_levels),
                                    32'(got.gate_levels));
                if (got.position !== want.position)
                    report_mismatch("position", want.position, got.position);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [2:0] set_homes [NUM_SETS];
        logic [2:0] hall;
        int rotor_pos;
        int turn;
        t_sample_row blank_row;
        fail_count      = 0;
        samples_sent    = 0;
        results_checked = 0;
        no_idle         = 1'b0;
        hold_request    = 1'b0;
        home_setting    = 3'd0;
        last_rotor      = 3'd0;
        position_count  = 32'd0;
        blank_row       = '0;
        rotor_pos       = 0;
        turn            = 1;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            if (SAMPLE_ROWS[k].home != home_setting) begin
                drain_results();
                write_home(SAMPLE_ROWS[k].home);
            end
            send_sample(SAMPLE_ROWS[k].hall, SAMPLE_ROWS[k].lead, SAMPLE_ROWS[k]);
        end

        set_homes = '{3'd5, 3'd0, 3'd7, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
        for (int s = 0; s < NUM_SETS; s++) begin
            drain_results();
            write_home(set_homes[s]);
            no_idle = (s == 3);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (s == 1 && n == 20)
                    hold_request = 1'b1;
                // mostly clean rotations with reversals, some raw sensor noise
                if ($urandom_range(0, 3) == 0) begin
                    hall = 3'($urandom_range(0, 7));
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        turn = -turn;
                    rotor_pos = (rotor_pos + turn + 6) % 6;
                    hall = ROTOR_TO_HALL[rotor_pos];
                end
                send_sample(hall, 3'($urandom_range(0, 7)), blank_row);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d samples over %0d home settings, %0d results checked.",
                 samples_sent, NUM_SETS + 3, results_checked);
        $display("Final position count %0d, %0d mismatches.", $signed(position_count),
                 fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bhc_pkg.sv
hw/rtl/bhc_commutate.sv
hw/rtl/bhc_position.sv
hw/rtl/bldc_hall_commutation.sv
verif/bldc_hall_commutation_tb.sv
